/* design/tal_pkg.sv */
// Package for the tree ancestor LCA engine: request codes, sequencer states, widths.
package tal_pkg;

    localparam int FIELD_W = 10;
    localparam int DIST_W  = 11;
    localparam logic [DIST_W-1:0] DIST_MAX = 11'd2046;

    typedef enum logic [1:0] {
        REQ_ATTACH = 2'd0,
        REQ_LCA    = 2'd1,
        REQ_KTH    = 2'd2,
        REQ_NONE   = 2'd3
    } t_req;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_AT_DEP,      // write depth of node (parent depth + 1)
        ST_AT_LVL,      // read anc[prev][i-1]
        ST_AT_WR,       // write anc[a][i]
        ST_Q_DEPA,      // read depth a
        ST_Q_DEPB,      // read depth b
        ST_Q_ALIGN,     // issue climb read for one bit
        ST_Q_ALIGN_W,   // take climb data
        ST_Q_CHK,
        ST_Q_LV,        // read lift(v,i)
        ST_Q_LW,        // read lift(w,i), latch lift(v,i)
        ST_Q_LW_W,
        ST_Q_PAR,       // read anc[w][0]
        ST_Q_PAR_W,
        ST_Q_DEPR,      // read depth of result
        ST_Q_DEPR_W,
        ST_Q_DIST,
        ST_OUT
    } t_state;

endpackage

/* design/tal_ram.sv */
// Generic single-port synchronous RAM with registered read.
module tal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* design/tree_ancestor_lca_engine_core.sv */
// Top level of the binary-lifting ancestor / LCA engine.
//
// Input channel: i_valid / o_stall with i_req_type, i_node_a, i_node_b, i_steps.
// Output channel: o_valid / i_stall with o_result_node, o_node_valid, o_distance.
// A beat is accepted when valid is high and stall is low.
//
// Attach (type 0) writes LEVELS ancestor entries and one depth and gives no
// result; o_stall stays high while the entries are written.
// LCA (type 1) reads both depths, walks the alignment bits (a read and a take
// per bit), runs LEVELS lift steps (read v, read w, compare), then reads the
// parent and its depth. Aligned nodes that already meet, or a failed climb, skip
// the lift steps and the parent read; the same node or an out-of-range index
// goes straight to the output register.
// Kth ancestor (type 2) walks the LEVELS bits of steps, a read and a take per
// bit; it ends after the first read when steps needs a level at or above
// LEVELS, and an out-of-range node_a goes straight to the output register.
// The walk is paced by the single port of the ancestor RAM: one entry a read.
// One request is in work at a time; a finished result sits in the output
// register while the receiver stalls, and the block holds o_stall until the
// result is taken. After reset a clearing pass writes all NODES*LEVELS ancestor
// entries invalid and all depths zero, one entry a cycle, with o_stall high.
module tree_ancestor_lca_engine_core
    import tal_pkg::*;
#(
    parameter int NODES  = 1024,
    parameter int LEVELS = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_req_type,
    input  logic [FIELD_W-1:0] i_node_a,
    input  logic [FIELD_W-1:0] i_node_b,
    input  logic [FIELD_W-1:0] i_steps,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [FIELD_W-1:0] o_result_node,
    output logic               o_node_valid,
    output logic [DIST_W-1:0]  o_distance
);
    localparam int NW   = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int LW   = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int AD   = NODES * LEVELS;
    localparam int AW   = $clog2(AD);
    localparam int EW   = NW + 1;              // valid + node
    localparam int CW   = AW + 1;

    // ancestor entry address: node*LEVELS + level
    function automatic logic [AW-1:0] f_addr(input logic [NW-1:0] n, input logic [LW-1:0] l);
        logic [AW+LW:0] t;
        t = (AW+LW+1)'(n) * (AW+LW+1)'(LEVELS) + (AW+LW+1)'(l);
        return t[AW-1:0];
    endfunction

    t_state r_state, n_state;

    logic [CW-1:0]      r_cnt, n_cnt;
    logic [1:0]         r_kind, n_kind;
    logic [FIELD_W-1:0] r_a, n_a, r_b, n_b, r_k, n_k;
    logic [LW-1:0]      r_lvl, n_lvl;
    logic               r_vok, n_vok, r_wok, n_wok;
    logic [NW-1:0]      r_v, n_v, r_w, n_w;
    logic [9:0]         r_da, n_da, r_db, n_db, r_dr, n_dr;
    logic [FIELD_W-1:0] r_diff, n_diff;
    logic               r_pvok, n_pvok;
    logic [NW-1:0]      r_pv, n_pv;
    logic               r_ok, n_ok;
    logic [FIELD_W-1:0] r_res, n_res;
    logic [DIST_W-1:0]  r_dist, n_dist;

    logic          a_we;
    logic [AW-1:0] a_addr;
    logic [EW-1:0] a_wd, a_rd;
    logic          d_we;
    logic [NW-1:0] d_addr;
    logic [9:0]    d_wd, d_rd;

    tal_ram #(.WIDTH(EW), .DEPTH(AD)) u_anc (
        .i_clk(i_clk), .i_we(a_we), .i_addr(a_addr), .i_wdata(a_wd), .o_rdata(a_rd));
    tal_ram #(.WIDTH(10), .DEPTH(NODES)) u_dep (
        .i_clk(i_clk), .i_we(d_we), .i_addr(d_addr), .i_wdata(d_wd), .o_rdata(d_rd));

    logic accept;
    assign accept  = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = (r_state == ST_OUT);
    assign o_result_node = r_res;
    assign o_node_valid  = r_ok;
    assign o_distance    = r_dist;

    logic a_in, b_in;
    assign a_in = (32'(i_node_a) < NODES);
    assign b_in = (32'(i_node_b) < NODES);

    // distance: da + db - 2*dr clamped
    logic signed [13:0] dist_s;
    assign dist_s = $signed({4'd0, r_da}) + $signed({4'd0, r_db})
                  - $signed({3'd0, r_dr, 1'b0});

    logic k_hi;
    assign k_hi = (LEVELS < FIELD_W) ? ((32'(r_k) >> LEVELS) != 0) : 1'b0;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR:   if (r_cnt == CW'(AD - 1)) n_state = ST_IDLE;
            ST_IDLE: begin
                if (accept) begin
                    case (i_req_type)
                        REQ_ATTACH: n_state = (a_in && b_in) ? ST_AT_DEP : ST_IDLE;
                        REQ_LCA: begin
                            if (!a_in || !b_in || i_node_a == i_node_b) n_state = ST_OUT;
                            else n_state = ST_Q_DEPA;
                        end
                        REQ_KTH:    n_state = a_in ? ST_Q_ALIGN : ST_OUT;
                        default:    n_state = ST_IDLE;
                    endcase
                end
            end
            ST_AT_DEP:  n_state = (LEVELS > 1) ? ST_AT_LVL : ST_IDLE;
            ST_AT_LVL:  n_state = ST_AT_WR;
            ST_AT_WR:   n_state = (32'(r_lvl) == LEVELS - 1) ? ST_IDLE : ST_AT_LVL;
            ST_Q_DEPA:  n_state = ST_Q_DEPB;
            ST_Q_DEPB:  n_state = ST_Q_ALIGN;
            ST_Q_ALIGN: begin
                // a kth step count beyond the table ends at once; an LCA
                // difference that large just walks with the node invalid
                if (r_kind == REQ_KTH && k_hi && r_lvl == LW'(LEVELS - 1))
                    n_state = ST_OUT;
                else n_state = ST_Q_ALIGN_W;
            end
            ST_Q_ALIGN_W: begin
                if (r_lvl == '0) n_state = (r_kind == REQ_KTH) ? ST_OUT : ST_Q_CHK;
                else n_state = ST_Q_ALIGN;
            end
            ST_Q_CHK: begin
                if (!r_vok || r_v == r_w) n_state = ST_Q_DEPR;
                else n_state = ST_Q_LV;
            end
            ST_Q_LV:    n_state = ST_Q_LW;
            ST_Q_LW:    n_state = ST_Q_LW_W;
            ST_Q_LW_W:  n_state = (r_lvl == '0) ? ST_Q_PAR : ST_Q_LV;
            ST_Q_PAR:   n_state = ST_Q_PAR_W;
            ST_Q_PAR_W: n_state = ST_Q_DEPR;
            ST_Q_DEPR:  n_state = ST_Q_DEPR_W;
            ST_Q_DEPR_W: n_state = ST_Q_DIST;
            ST_Q_DIST:  n_state = ST_OUT;
            ST_OUT:     if (!i_stall) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        logic          bit_set;
        logic          lv_ok;
        bit_set = 1'b0;
        lv_ok   = 1'b0;
        n_cnt = r_cnt; n_kind = r_kind; n_a = r_a; n_b = r_b; n_k = r_k;
        n_lvl = r_lvl; n_vok = r_vok; n_wok = r_wok; n_v = r_v; n_w = r_w;
        n_da = r_da; n_db = r_db; n_dr = r_dr; n_diff = r_diff;
        n_pvok = r_pvok; n_pv = r_pv; n_ok = r_ok; n_res = r_res; n_dist = r_dist;
        a_we = 1'b0; a_addr = '0; a_wd = '0;
        d_we = 1'b0; d_addr = '0; d_wd = '0;
        case (r_state)
            ST_CLEAR: begin
                a_we = 1'b1; a_addr = r_cnt[AW-1:0];
                d_we = 32'(r_cnt) < NODES; d_addr = r_cnt[NW-1:0];
                n_cnt = r_cnt + 1'b1;
            end
            ST_IDLE: begin
                n_kind = i_req_type; n_a = i_node_a; n_b = i_node_b; n_k = i_steps;
                n_v = i_node_a[NW-1:0]; n_w = i_node_b[NW-1:0];
                n_vok = 1'b1; n_wok = 1'b1;
                n_lvl = LW'(LEVELS - 1);
                n_ok = 1'b0; n_res = '0; n_dist = '0;
                if (accept && i_req_type == REQ_ATTACH && a_in && b_in) begin
                    d_addr = i_node_b[NW-1:0];   // parent depth
                    a_we = 1'b1; a_addr = f_addr(i_node_a[NW-1:0], '0);
                    a_wd = {1'b1, i_node_b[NW-1:0]};
                    n_lvl = '0;
                    n_pvok = 1'b1; n_pv = i_node_b[NW-1:0];
                end
                if (accept && i_req_type == REQ_LCA) begin
                    d_addr = i_node_a[NW-1:0];
                    if (a_in && b_in && i_node_a == i_node_b) begin
                        n_ok = 1'b1; n_res = i_node_a;
                    end
                end
            end
            ST_AT_DEP: begin
                d_we = 1'b1; d_addr = r_a[NW-1:0];
                d_wd = (d_rd == 10'd1023) ? 10'd1023 : d_rd + 10'd1;
            end
            ST_AT_LVL: begin
                a_addr = f_addr(r_pv, r_lvl);
                n_lvl = r_lvl + 1'b1;
            end
            ST_AT_WR: begin
                lv_ok = r_pvok && a_rd[EW-1];
                a_we = 1'b1; a_addr = f_addr(r_a[NW-1:0], r_lvl);
                a_wd = lv_ok ? a_rd : '0;
                n_pvok = lv_ok; n_pv = a_rd[NW-1:0];
            end
            ST_Q_DEPA: begin
                n_da = d_rd;
                d_addr = r_b[NW-1:0];
            end
            ST_Q_DEPB: begin
                d_addr = r_b[NW-1:0];   // keep depth b on the port for the first align step
            end
            ST_Q_ALIGN: begin
                if (r_kind != REQ_KTH && r_lvl == LW'(LEVELS - 1)) begin
                    // first step: latch depth b, order nodes, compute difference
                    n_db = d_rd;
                    if (r_da < d_rd) begin
                        n_v = r_b[NW-1:0]; n_w = r_a[NW-1:0];
                        n_diff = d_rd - r_da;
                    end else begin
                        n_diff = r_da - d_rd;
                    end
                    bit_set = 1'b0;
                end
                a_addr = f_addr(n_v, r_lvl);
                if (r_kind == REQ_KTH && k_hi) n_vok = 1'b0;
                if (r_kind != REQ_KTH && r_lvl == LW'(LEVELS - 1)
                    && (LEVELS < FIELD_W) && ((32'(n_diff) >> LEVELS) != 0))
                    n_vok = 1'b0;
            end
            ST_Q_ALIGN_W: begin
                bit_set = (r_kind == REQ_KTH) ? r_k[r_lvl] : r_diff[r_lvl];
                if (bit_set) begin
                    lv_ok = r_vok && a_rd[EW-1];
                    n_vok = lv_ok; n_v = lv_ok ? a_rd[NW-1:0] : '0;
                end
                if (r_lvl != '0) n_lvl = r_lvl - 1'b1;
                else n_lvl = LW'(LEVELS - 1);
                if (r_lvl == '0 && r_kind == REQ_KTH) begin
                    n_ok = n_vok; n_res = n_vok ? FIELD_W'(n_v) : '0;
                end
            end
            ST_Q_CHK: begin
                n_wok = 1'b1;
                n_pvok = r_vok; n_pv = r_v;   // result when aligned equals w
            end
            ST_Q_LV: begin
                a_addr = f_addr(r_v, r_lvl);
            end
            ST_Q_LW: begin
                n_pvok = r_vok && a_rd[EW-1]; n_pv = a_rd[NW-1:0];
                a_addr = f_addr(r_w, r_lvl);
            end
            ST_Q_LW_W: begin
                lv_ok = r_wok && a_rd[EW-1];
                if (r_pvok != lv_ok || (r_pvok && r_pv != a_rd[NW-1:0])) begin
                    n_vok = r_pvok; n_v = r_pvok ? r_pv : '0;
                    n_wok = lv_ok;  n_w = lv_ok ? a_rd[NW-1:0] : '0;
                end
                if (r_lvl != '0) n_lvl = r_lvl - 1'b1;
            end
            ST_Q_PAR: begin
                a_addr = f_addr(r_w, '0);
            end
            ST_Q_PAR_W: begin
                n_pvok = r_wok && a_rd[EW-1]; n_pv = a_rd[NW-1:0];
            end
            ST_Q_DEPR: begin
                d_addr = r_pv;
            end
            ST_Q_DEPR_W: begin
                n_dr = d_rd;
            end
            ST_Q_DIST: begin
                n_ok = r_pvok; n_res = r_pvok ? FIELD_W'(r_pv) : '0;
                if (!r_pvok) n_dist = '0;
                else if (dist_s < 0) n_dist = '0;
                else if (dist_s > 14'sd2046) n_dist = DIST_MAX;
                else n_dist = dist_s[DIST_W-1:0];
            end
            ST_OUT: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_kind <= n_kind; r_a <= n_a; r_b <= n_b; r_k <= n_k; r_lvl <= n_lvl;
        r_vok <= n_vok; r_wok <= n_wok; r_v <= n_v; r_w <= n_w;
        r_da <= n_da; r_db <= n_db; r_dr <= n_dr; r_diff <= n_diff;
        r_pvok <= n_pvok; r_pv <= n_pv; r_ok <= n_ok; r_res <= n_res; r_dist <= n_dist;
    end

    // a result beat never reports distance without a valid node
    a_dist_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_node_valid |-> o_distance == '0)
        else $error("distance nonzero on invalid result");

    // a stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_node) && $stable(o_distance))
        else $error("result changed while stalled");

    // no new request while a result is pending
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while result pending");
endmodule

/* tb/sv/tree_ancestor_lca_engine_core_test.sv */
// Testbench for the binary-lifting ancestor / LCA engine: scoreboard against a local forest model.
module tree_ancestor_lca_engine_core_test
    import tal_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NODES  = 1024;
    localparam int LEVELS = 10;

    typedef struct packed {
        logic [FIELD_W-1:0] node;
        logic               ok;
        logic [DIST_W-1:0]  span;
    } t_answer;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [1:0]         i_req_type = REQ_ATTACH;
    logic [FIELD_W-1:0] i_node_a = '0;
    logic [FIELD_W-1:0] i_node_b = '0;
    logic [FIELD_W-1:0] i_steps = '0;
    logic               o_valid;
    logic               i_stall = 1'b1;
    logic [FIELD_W-1:0] o_result_node;
    logic               o_node_valid;
    logic [DIST_W-1:0]  o_distance;

    tree_ancestor_lca_engine_core #(.NODES(NODES), .LEVELS(LEVELS)) uut (.*);

    always #2 i_clk = ~i_clk;

    // Local copy of the forest: lifted ancestors with valid bits, and depths.
    logic               up_ok   [NODES][LEVELS];
    logic [FIELD_W-1:0] up_node [NODES][LEVELS];
    logic [9:0]         depth   [NODES];

    t_answer answers_due[$];
    int      errors = 0;
    int      beats_sent = 0;
    int      answers_seen = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;

    function automatic void forest_clear();
        for (int n = 0; n < NODES; n++) begin
            depth[n] = '0;
            for (int l = 0; l < LEVELS; l++) begin
                up_ok[n][l] = 1'b0;
                up_node[n][l] = '0;
            end
        end
    endfunction

    // One lift step; an invalid link stays invalid.
    function automatic void hop(inout logic ok, inout logic [FIELD_W-1:0] n, input int l);
        logic [FIELD_W-1:0] cur;
        cur = n;
        if (!ok) begin
            n = '0;
        end else begin
            ok = up_ok[cur][l];
            n  = up_node[cur][l];
        end
    endfunction

    function automatic void climb_by(inout logic ok, inout logic [FIELD_W-1:0] n,
                                     input logic [FIELD_W-1:0] k);
        for (int l = LEVELS - 1; l >= 0; l--)
            if (k[l]) hop(ok, n, l);
    endfunction

    function automatic t_answer lca_of(logic [FIELD_W-1:0] a, logic [FIELD_W-1:0] b);
        t_answer r;
        logic [FIELD_W-1:0] x, y, t, pv, pw;
        logic vok, wok, pvok, pwok;
        int d;
        r = '0;
        if (a == b) begin
            r.node = a;
            r.ok = 1'b1;
            return r;
        end
        x = a;
        y = b;
        if (depth[x] < depth[y]) begin
            t = x; x = y; y = t;
        end
        vok = 1'b1;
        wok = 1'b1;
        climb_by(vok, x, depth[x] - depth[y]);
        if (!vok) return r;
        if (x != y) begin
            for (int l = LEVELS - 1; l >= 0; l--) begin
                pvok = vok; pv = x; hop(pvok, pv, l);
                pwok = wok; pw = y; hop(pwok, pw, l);
                if (pvok != pwok || (pvok && pv != pw)) begin
                    vok = pvok; x = pv; wok = pwok; y = pw;
                end
            end
            hop(wok, y, 0);
            if (!wok) return r;
            x = y;
        end
        d = int'(depth[a]) + int'(depth[b]) - 2 * int'(depth[x]);
        if (d < 0) d = 0;
        if (d > 2046) d = 2046;
        r.node = x;
        r.ok = 1'b1;
        r.span = DIST_W'(d);
        return r;
    endfunction

    function automatic void queue_answer(t_answer r);
        answers_due.insert(answers_due.size(), r);
    endfunction

    // Apply one request to the local forest and queue its answer, if any.
    function automatic void forest_apply(t_req kind, logic [FIELD_W-1:0] a,
                                         logic [FIELD_W-1:0] b, logic [FIELD_W-1:0] k);
        t_answer r;
        logic ok;
        logic [FIELD_W-1:0] n;
        case (kind)
            REQ_ATTACH: begin
                up_ok[a][0] = 1'b1;
                up_node[a][0] = b;
                for (int l = 1; l < LEVELS; l++) begin
                    ok = up_ok[a][l-1];
                    n = up_node[a][l-1];
                    hop(ok, n, l - 1);
                    up_ok[a][l] = ok;
                    up_node[a][l] = n;
                end
                depth[a] = (depth[b] == 10'd1023) ? 10'd1023 : depth[b] + 10'd1;
            end
            REQ_LCA: queue_answer(lca_of(a, b));
            REQ_KTH: begin
                ok = 1'b1;
                n = a;
                climb_by(ok, n, k);
                r = '0;
                if (ok) begin
                    r.ok = 1'b1;
                    r.node = n;
                end
                queue_answer(r);
            end
            default: ;
        endcase
    endfunction

    // Send one beat; the sender may idle before it. Valid stays up after the
    // accepting edge until the next beat or an idle cycle replaces it.
    task automatic send_beat(t_req kind, int a, int b, int k);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= kind;
        i_node_a <= FIELD_W'(a);
        i_node_b <= FIELD_W'(b);
        i_steps <= FIELD_W'(k);
        forest_apply(kind, FIELD_W'(a), FIELD_W'(b), FIELD_W'(k));
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        beats_sent++;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    // Receiver stall and result checking.
    always @(posedge i_clk) begin
        t_answer exp_r;
        if (i_rst_n && o_valid && !i_stall) begin
            answers_seen++;
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result node=%0d ok=%0d dist=%0d",
                         $time, o_result_node, o_node_valid, o_distance);
                errors++;
            end else begin
                exp_r = answers_due.pop_front();
                if (o_result_node !== exp_r.node || o_node_valid !== exp_r.ok
                        || o_distance !== exp_r.span) begin
                    $display("%0t: mismatch expected node=%0d ok=%0d dist=%0d, got %0d %0d %0d",
                             $time, exp_r.node, exp_r.ok, exp_r.span,
                             o_result_node, o_node_valid, o_distance);
                    errors++;
                end
            end
        end
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // Directed: chain 0-1-2-3, branch 4 under 1, separate tree at 10.
    task automatic test_directed();
        send_beat(REQ_LCA, 5, 5, 0);          // same node
        send_beat(REQ_KTH, 7, 0, 0);
        send_beat(REQ_KTH, 7, 0, 1);          // above a root
        send_beat(REQ_ATTACH, 1, 0, 0);
        send_beat(REQ_ATTACH, 2, 1, 0);
        send_beat(REQ_ATTACH, 3, 2, 0);
        send_beat(REQ_ATTACH, 4, 1, 0);
        send_beat(REQ_ATTACH, 11, 10, 0);
        send_beat(REQ_LCA, 3, 4, 0);
        send_beat(REQ_LCA, 4, 3, 0);
        send_beat(REQ_LCA, 3, 0, 0);
        send_beat(REQ_LCA, 3, 11, 0);         // different trees
        send_beat(REQ_KTH, 3, 0, 3);
        send_beat(REQ_KTH, 3, 0, 1023);
        send_beat(REQ_KTH, 1023, 0, 512);
        send_beat(REQ_NONE, 1023, 1023, 1023);
        send_beat(REQ_ATTACH, 0, 3, 0);       // makes a cycle
        send_beat(REQ_LCA, 0, 4, 0);
        send_beat(REQ_KTH, 2, 0, 5);
        send_beat(REQ_ATTACH, 1023, 1023, 0); // self loop
        send_beat(REQ_LCA, 1023, 0, 0);
        send_beat(REQ_KTH, 1023, 0, 1000);
        wait_drained();
    endtask

    // A long chain of attaches builds deep nodes; this test sends no queries itself.
    task automatic test_deep_chain();
        for (int n = 100; n < 1023; n += 1) begin
            send_beat(REQ_ATTACH, n + 1, n, 0);
        end
        wait_drained();
    endtask

    // Random: grow small forests in a node window and query them.
    task automatic test_random(int count);
        int lo, a, b, op;
        lo = $urandom_range(0, 960);
        for (int i = 0; i < count; i++) begin
            if (i % 300 == 0) lo = $urandom_range(0, 960);
            op = $urandom_range(0, 99);
            a = lo + $urandom_range(0, 63);
            b = lo + $urandom_range(0, 63);
            if (op < 35) begin
                if (b >= a && a > 0 && $urandom_range(0, 9) != 0) b = $urandom_range(0, a - 1);
                send_beat(REQ_ATTACH, a, b, 0);
            end else if (op < 70) begin
                send_beat(REQ_LCA, a, b, 0);
            end else if (op < 95) begin
                send_beat(REQ_KTH, a, 0, ($urandom_range(0, 3) == 0) ?
                          $urandom_range(0, 1023) : $urandom_range(0, 12));
            end else if (op < 98) begin
                send_beat(REQ_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023),
                          $urandom_range(0, 1023));
            end else begin
                send_beat(REQ_LCA, $urandom_range(0, 1023), $urandom_range(0, 1023), 0);
            end
        end
    endtask

    initial begin
        forest_clear();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 35;
        recv_idle_pct = 70;
        test_directed();
        test_deep_chain();
        test_random(350);
        wait_drained();                       // sender holds off until all answers arrive
        send_idle_pct = 70;
        recv_idle_pct = 35;
        test_random(350);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(350);
        wait_drained();
        $display("Covered attach, LCA and kth-ancestor requests: %0d beats, %0d results.",
                 beats_sent, answers_seen);
        if (errors == 0 && answers_due.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
